// ===== hdl/ntp_pkg.sv =====
// shared types, character codes and constants for the number token parser
// no dependencies
package ntp_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int NUMBER_W        = 32;
	localparam int CHAR_W          = 8;
	localparam int COUNT_W         = 8;
	localparam int FRAC_W          = 20;
	localparam int FDIG_W          = 3;
	localparam int CFG_IDX_W       = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_HEX_ENABLE    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SUFFIX_ENABLE = 1'b1;

	localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
	localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
	localparam logic [CHAR_W-1:0] CH_F     = 8'h66;
	localparam logic [CHAR_W-1:0] CH_H     = 8'h68;
	localparam logic [CHAR_W-1:0] CH_K     = 8'h6B;
	localparam logic [CHAR_W-1:0] CH_M     = 8'h6D;
	localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
	localparam logic [CHAR_W-1:0] CASE_BIT = 8'h20;

	localparam logic [FDIG_W-1:0] KILO_DIGITS = 3'd3;
	localparam logic [FDIG_W-1:0] MEGA_DIGITS = 3'd6;

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_DEC  = 4'b0010,
		PH_HEX  = 4'b0100,
		PH_FRAC = 4'b1000
	} phase_t;

	// weight of one fraction digit by its distance from the last kept place
	function automatic logic [FRAC_W-1:0] pow10(input logic [FDIG_W-1:0] e);
		logic [FRAC_W-1:0] r;
		case (e)
			3'd0: r = 20'd1;
			3'd1: r = 20'd10;
			3'd2: r = 20'd100;
			3'd3: r = 20'd1000;
			3'd4: r = 20'd10000;
			3'd5: r = 20'd100000;
			default: r = 20'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/ntp_in_if.sv =====
// character input channel of the number token parser
// depends on ntp_pkg
interface ntp_in_if;
	logic                           valid;
	logic                           ready;
	logic [ntp_pkg::CHAR_W-1:0]     char_in;
	logic                           start_req;

	modport source (output valid, output char_in, output start_req, input ready);
	modport sink   (input valid, input char_in, input start_req, output ready);
endinterface

// ===== hdl/ntp_out_if.sv =====
// result channel of the number token parser
// depends on ntp_pkg
interface ntp_out_if;
	logic                           valid;
	logic                           ready;
	logic                           ok;
	logic [ntp_pkg::NUMBER_W-1:0]   number;
	logic [ntp_pkg::COUNT_W-1:0]    consumed;
	logic                           was_hex;

	modport source (output valid, output ok, output number, output consumed, output was_hex,
		input ready);
	modport sink   (input valid, input ok, input number, input consumed, input was_hex,
		output ready);
endinterface

// ===== hdl/ntp_cfg_if.sv =====
// configuration write channel of the number token parser
// depends on ntp_pkg
interface ntp_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [ntp_pkg::CFG_IDX_W-1:0]     index;
	logic                              data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/number_token_parser_top.sv =====
// number token parser: streaming ascii decimal / hex number parser
// depends on ntp_pkg, ntp_in_if, ntp_out_if, ntp_cfg_if
//
// usage:
//   in_ch carries one character a beat with start_req marking the first
//   character of a token. a token is decimal, decimal with k / m suffix and
//   fraction digits, or hex after a 0x / 0h / x / h prefix. the first
//   character that does not fit ends the token and yields one beat on out_ch
//   (ok, number, consumed, was_hex); that character is not part of any token.
//   cfg_ch writes hex_enable (index 0) and suffix_enable (index 1); it is
//   always ready and should be used only while the parser is idle.
// timing:
//   one character per cycle sustained while out_ch is not held. a character
//   taken sits in the input register and is parsed from there; the result
//   of an ending character is registered in the result register for out_ch.
//   the running state is one register set updated once per character.
// reset: token state cleared, both enables set to 1, no result pending.
// stall: while out_ch is held, one more character waits in the input
//   register; further characters are refused until the result is taken.
module number_token_parser_top #(
	parameter int VALUE_WIDTH = ntp_pkg::VALUE_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ntp_in_if.sink    in_ch,
	ntp_out_if.source out_ch,
	ntp_cfg_if.sink   cfg_ch
);

	localparam logic [VALUE_WIDTH-1:0] SCALE_K = VALUE_WIDTH'(1000);
	localparam logic [VALUE_WIDTH-1:0] SCALE_M = VALUE_WIDTH'(1000000);

	// configuration
	logic hex_en_q;
	logic sfx_en_q;

	// input register
	logic                          valid_s1;
	logic [ntp_pkg::CHAR_W-1:0]    char_s1;
	logic                          start_s1;

	// token state
	ntp_pkg::phase_t               phase_q, phase_d;
	logic [VALUE_WIDTH-1:0]        accum_q, accum_d;
	logic [ntp_pkg::FRAC_W-1:0]    frac_q, frac_d;
	logic [ntp_pkg::FDIG_W-1:0]    fdig_q, fdig_d;
	logic                          mega_q, mega_d;
	logic [ntp_pkg::COUNT_W-1:0]   cnt_q, cnt_d;
	logic                          seen_q, seen_d;

	// result register
	logic                          out_valid_q;
	logic                          ok_q;
	logic [ntp_pkg::NUMBER_W-1:0]  number_q;
	logic [ntp_pkg::COUNT_W-1:0]   consumed_q;
	logic                          was_hex_q;

	logic                          adv;
	logic                          emit;
	logic                          emit_ok;
	logic [VALUE_WIDTH-1:0]        emit_val;
	logic [ntp_pkg::COUNT_W-1:0]   emit_cnt;
	logic                          emit_hex;

	logic [ntp_pkg::CHAR_W-1:0]    lc;
	logic                          is_dig;
	logic                          is_hexl;
	logic                          is_pfx;
	logic                          is_sfx;
	logic [3:0]                    dval;
	logic [3:0]                    hval;
	logic [ntp_pkg::COUNT_W-1:0]   cnt_inc;
	logic [ntp_pkg::FDIG_W-1:0]    limit;
	logic [ntp_pkg::FDIG_W-1:0]    fidx;

	assign adv          = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || adv;
	assign cfg_ch.ready = 1'b1;

	assign out_ch.valid    = out_valid_q;
	assign out_ch.ok       = ok_q;
	assign out_ch.number   = number_q;
	assign out_ch.consumed = consumed_q;
	assign out_ch.was_hex  = was_hex_q;

	// character classes
	assign lc      = (char_s1 >= ntp_pkg::CH_UP_A && char_s1 <= ntp_pkg::CH_UP_Z) ?
		(char_s1 | ntp_pkg::CASE_BIT) : char_s1;
	assign is_dig  = (char_s1 >= ntp_pkg::CH_0) && (char_s1 <= ntp_pkg::CH_9);
	assign is_hexl = (lc >= ntp_pkg::CH_A) && (lc <= ntp_pkg::CH_F);
	assign is_pfx  = (lc == ntp_pkg::CH_X) || (lc == ntp_pkg::CH_H);
	assign is_sfx  = (lc == ntp_pkg::CH_K) || (lc == ntp_pkg::CH_M);
	assign dval    = 4'(char_s1 - ntp_pkg::CH_0);
	assign hval    = is_dig ? dval : 4'(lc - ntp_pkg::CH_A + 8'd10);
	assign cnt_inc = (cnt_q == {ntp_pkg::COUNT_W{1'b1}}) ? cnt_q : cnt_q + 8'd1;
	assign limit   = mega_q ? ntp_pkg::MEGA_DIGITS : ntp_pkg::KILO_DIGITS;
	assign fidx    = 3'(limit - 3'd1 - fdig_q);

	always_comb begin
		phase_d  = phase_q;
		accum_d  = accum_q;
		frac_d   = frac_q;
		fdig_d   = fdig_q;
		mega_d   = mega_q;
		cnt_d    = cnt_q;
		seen_d   = seen_q;
		emit     = 1'b0;
		emit_ok  = 1'b0;
		emit_val = '0;
		emit_cnt = cnt_q;
		emit_hex = 1'b0;
		if (start_s1) begin
			phase_d = ntp_pkg::PH_IDLE;
			accum_d = '0;
			frac_d  = '0;
			fdig_d  = '0;
			mega_d  = 1'b0;
			cnt_d   = '0;
			seen_d  = 1'b0;
			if (is_dig) begin
				phase_d = ntp_pkg::PH_DEC;
				accum_d = VALUE_WIDTH'(dval);
				seen_d  = 1'b1;
				cnt_d   = 8'd1;
			end else if (is_pfx && hex_en_q) begin
				phase_d = ntp_pkg::PH_HEX;
				cnt_d   = 8'd1;
			end else begin
				emit     = 1'b1;
				emit_cnt = '0;
			end
		end else begin
			unique case (phase_q)
				ntp_pkg::PH_IDLE: begin
				end
				ntp_pkg::PH_DEC: begin
					if (is_dig) begin
						accum_d = (accum_q << 3) + (accum_q << 1) + VALUE_WIDTH'(dval);
						cnt_d   = cnt_inc;
					end else if (is_pfx && hex_en_q && cnt_q == 8'd1 && accum_q == '0) begin
						phase_d = ntp_pkg::PH_HEX;
						accum_d = '0;
						seen_d  = 1'b0;
						cnt_d   = cnt_inc;
					end else if (is_sfx && sfx_en_q) begin
						phase_d = ntp_pkg::PH_FRAC;
						mega_d  = (lc == ntp_pkg::CH_M);
						accum_d = accum_q * ((lc == ntp_pkg::CH_M) ? SCALE_M : SCALE_K);
						cnt_d   = cnt_inc;
					end else begin
						emit     = 1'b1;
						emit_ok  = 1'b1;
						emit_val = accum_q;
					end
				end
				ntp_pkg::PH_HEX: begin
					if (is_dig || is_hexl) begin
						accum_d = (accum_q << 4) | VALUE_WIDTH'(hval);
						seen_d  = 1'b1;
						cnt_d   = cnt_inc;
					end else begin
						emit     = 1'b1;
						emit_ok  = seen_q;
						emit_val = seen_q ? accum_q : '0;
						emit_hex = 1'b1;
					end
				end
				ntp_pkg::PH_FRAC: begin
					if (is_dig) begin
						if (fdig_q < limit) begin
							frac_d = frac_q + 20'(20'(dval) * ntp_pkg::pow10(fidx));
							fdig_d = fdig_q + 3'd1;
						end
						cnt_d = cnt_inc;
					end else begin
						emit     = 1'b1;
						emit_ok  = 1'b1;
						emit_val = accum_q + VALUE_WIDTH'(frac_q);
					end
				end
				default: begin
				end
			endcase
			if (emit) begin
				phase_d = ntp_pkg::PH_IDLE;
				accum_d = '0;
				frac_d  = '0;
				fdig_d  = '0;
				mega_d  = 1'b0;
				cnt_d   = '0;
				seen_d  = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hex_en_q <= 1'b1;
			sfx_en_q <= 1'b1;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.index)
				ntp_pkg::CFG_HEX_ENABLE:    hex_en_q <= cfg_ch.data;
				ntp_pkg::CFG_SUFFIX_ENABLE: sfx_en_q <= cfg_ch.data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			char_s1  <= in_ch.char_in;
			start_s1 <= in_ch.start_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ntp_pkg::PH_IDLE;
			accum_q <= '0;
			frac_q  <= '0;
			fdig_q  <= '0;
			mega_q  <= 1'b0;
			cnt_q   <= '0;
			seen_q  <= 1'b0;
		end else if (adv) begin
			phase_q <= phase_d;
			accum_q <= accum_d;
			frac_q  <= frac_d;
			fdig_q  <= fdig_d;
			mega_q  <= mega_d;
			cnt_q   <= cnt_d;
			seen_q  <= seen_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= emit;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			ok_q       <= emit_ok;
			number_q   <= ntp_pkg::NUMBER_W'(emit_val);
			consumed_q <= emit_cnt;
			was_hex_q  <= emit_hex;
		end
	end

	// a decimal token always holds a digit
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == ntp_pkg::PH_DEC) |-> seen_q)
		else $error("decimal phase without digit");

	// kept fraction digits never pass the suffix limit
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == ntp_pkg::PH_FRAC) |-> (fdig_q <= limit))
		else $error("fraction digit count over limit");

	// no open token means nothing counted
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == ntp_pkg::PH_IDLE) |-> (cnt_q == '0 && accum_q == '0))
		else $error("idle phase with stale token state");

	// a start beat with a digit opens a decimal token
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv && start_s1 && is_dig) |=> (phase_q == ntp_pkg::PH_DEC))
		else $error("digit start did not open decimal token");

	// a result only appears after a parsed character
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv && emit))
		else $error("result without ending character");

endmodule
